// File: sv/osrb_pkg.sv
// ----------------------------------------------------------------------------
// osrb_pkg
// Shared types and constants for the overwriting sample ring buffer.
// ----------------------------------------------------------------------------
package osrb_pkg;

	localparam int DEPTH_DEF   = 4096;
	localparam int MAX_RUN_DEF = 64;

	localparam int CAP_W    = 13;
	localparam int SAMPLE_W = 32;
	localparam int REQ_W    = 7;
	localparam int CAP_RESET = 4096;

	typedef enum logic [1:0] {
		CMD_ENQ   = 2'd0,
		CMD_DEQ   = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_CLEAR = 2'd3
	} command_t;

	typedef enum logic [1:0] {
		ST_DATA   = 2'd0,
		ST_DONE   = 2'd1,
		ST_REJECT = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	typedef struct packed {
		logic [1:0]          command;
		logic [SAMPLE_W-1:0] sample;
		logic [REQ_W-1:0]    request_count;
	} in_item_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [SAMPLE_W-1:0] sample_out;
		logic [CAP_W-1:0]    fill_level;
		logic                last;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic enq;
		logic clr;
		logic query;
		logic reject;
		logic load;
		logic step;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic slot_free;
		logic reject;
		logic run_last;
	} dp_status_t;

endpackage

// File: sv/overwriting_sample_ring_buffer.sv
// ----------------------------------------------------------------------------
// overwriting_sample_ring_buffer
// Ring buffer of raw 32-bit samples that overwrites the oldest when full.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready/in_item; results leave on
// out_valid/out_ready/out_item. cfg_we/cfg_wdata set the capacity and empty
// the buffer; write it only while no request is in progress.
// Enqueue, query and clear give one result each through the result stage
// and the output queue. A dequeue run loads its count on acceptance, then
// gives one sample per cycle while the output queue has room; the next
// request is taken once the final read of the run is issued. Run rate
// is set by the store's single read port and its registered read data.
// Results pass through a two-entry output queue, so a request can be taken
// while an earlier result waits. When the receiver stalls the queue fills,
// reads pause and in_ready drops until there is room again.
// Reset empties the buffer and sets the capacity to 4096 (or DEPTH if
// smaller). The store itself is not cleared; only written slots are read.
// ----------------------------------------------------------------------------
module overwriting_sample_ring_buffer #(
	parameter int DEPTH   = osrb_pkg::DEPTH_DEF,
	parameter int MAX_RUN = osrb_pkg::MAX_RUN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [osrb_pkg::CAP_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  osrb_pkg::in_item_t         in_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output osrb_pkg::out_item_t        out_item
);

	osrb_pkg::dp_cmd_t    dp_cmd;
	osrb_pkg::dp_status_t dp_status;

	osrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (in_item.command),
		.dp_status (dp_status),
		.dp_cmd    (dp_cmd)
	);

	osrb_dp #(
		.DEPTH   (DEPTH),
		.MAX_RUN (MAX_RUN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_item   (in_item),
		.dp_cmd    (dp_cmd),
		.dp_status (dp_status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// File: sv/osrb_ctrl.sv
// ----------------------------------------------------------------------------
// osrb_ctrl
// Request sequencer: decodes accepted requests and steps dequeue runs.
// ----------------------------------------------------------------------------
module osrb_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             command,
	input  osrb_pkg::dp_status_t   dp_status,
	output osrb_pkg::dp_cmd_t      dp_cmd
);

	osrb_pkg::state_t state_q;
	osrb_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= osrb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		dp_cmd   = '0;
		case (state_q)
			osrb_pkg::S_IDLE: begin
				in_ready = dp_status.slot_free;
				if (in_valid && dp_status.slot_free) begin
					case (command)
						osrb_pkg::CMD_ENQ:   dp_cmd.enq = 1'b1;
						osrb_pkg::CMD_DEQ: begin
							if (dp_status.reject) begin
								dp_cmd.reject = 1'b1;
							end else begin
								dp_cmd.load = 1'b1;
								state_d     = osrb_pkg::S_RUN;
							end
						end
						osrb_pkg::CMD_QUERY: dp_cmd.query = 1'b1;
						osrb_pkg::CMD_CLEAR: dp_cmd.clr = 1'b1;
						default: ;
					endcase
				end
			end
			osrb_pkg::S_RUN: begin
				// one sample read per cycle while the output queue has room
				if (dp_status.slot_free) begin
					dp_cmd.step = 1'b1;
					if (dp_status.run_last) begin
						state_d = osrb_pkg::S_IDLE;
					end
				end
			end
			default: state_d = osrb_pkg::S_IDLE;
		endcase
	end

endmodule

// File: sv/osrb_dp.sv
// ----------------------------------------------------------------------------
// osrb_dp
// Datapath: sample store, pointers, fill count, result stage and output queue.
// ----------------------------------------------------------------------------
module osrb_dp #(
	parameter int DEPTH   = osrb_pkg::DEPTH_DEF,
	parameter int MAX_RUN = osrb_pkg::MAX_RUN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [osrb_pkg::CAP_W-1:0]    cfg_wdata,
	input  osrb_pkg::in_item_t            in_item,
	input  osrb_pkg::dp_cmd_t             dp_cmd,
	output osrb_pkg::dp_status_t          dp_status,
	output logic                          out_valid,
	input  logic                          out_ready,
	output osrb_pkg::out_item_t           out_item
);

	localparam int CAP_W   = osrb_pkg::CAP_W;
	localparam int PTR_W   = $clog2(DEPTH);
	localparam int CMP_W   = (PTR_W + 1 > CAP_W) ? PTR_W + 1 : CAP_W;
	localparam int CAP_MAX = (1 << CAP_W) - 1;
	localparam int DEPTH_CAP = (DEPTH > CAP_MAX) ? CAP_MAX : DEPTH;
	localparam int CAP_RST = (DEPTH < osrb_pkg::CAP_RESET) ? DEPTH : osrb_pkg::CAP_RESET;

	logic [osrb_pkg::SAMPLE_W-1:0] mem [DEPTH];

	logic [PTR_W-1:0]            rp_q;
	logic [PTR_W-1:0]            wp_q;
	logic [CAP_W-1:0]            fill_q;
	logic [CAP_W-1:0]            cap_q;
	logic [osrb_pkg::REQ_W-1:0]  remain_q;

	logic                          valid_s1;
	logic [1:0]                    status_s1;
	logic [CAP_W-1:0]              fill_s1;
	logic                          last_s1;
	logic                          is_data_s1;
	logic [osrb_pkg::SAMPLE_W-1:0] rd_s1;

	logic                 out_valid_q;
	osrb_pkg::out_item_t  out_q;
	logic                 skid_valid_q;
	osrb_pkg::out_item_t  skid_q;

	logic                 issue;
	logic                 full;
	logic [CAP_W-1:0]     fill_after;
	logic [1:0]           status_d;
	logic [CAP_W-1:0]     cap_wr;
	logic [CAP_W-1:0]     req_ext;
	logic                 pop;
	logic [1:0]           occupancy;
	osrb_pkg::out_item_t  push_item;

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
	                                             input logic [CAP_W-1:0] cap);
		logic [CMP_W-1:0] n;
		n = CMP_W'(p) + CMP_W'(1);
		return (n >= CMP_W'(cap)) ? '0 : PTR_W'(n);
	endfunction

	// capacity of zero acts as one, above DEPTH acts as DEPTH
	always_comb begin
		if (cfg_wdata == '0) begin
			cap_wr = CAP_W'(1);
		end else if (32'(cfg_wdata) > 32'(DEPTH_CAP)) begin
			cap_wr = CAP_W'(DEPTH_CAP);
		end else begin
			cap_wr = cfg_wdata;
		end
	end

	assign req_ext = CAP_W'(in_item.request_count);
	assign full    = (fill_q >= cap_q);
	assign issue   = dp_cmd.enq | dp_cmd.clr | dp_cmd.query | dp_cmd.reject | dp_cmd.step;

	always_comb begin
		fill_after = fill_q;
		status_d   = osrb_pkg::ST_DONE;
		if (dp_cmd.enq) begin
			fill_after = full ? cap_q : fill_q + CAP_W'(1);
		end else if (dp_cmd.clr) begin
			fill_after = '0;
		end else if (dp_cmd.step) begin
			fill_after = fill_q - CAP_W'(1);
			status_d   = osrb_pkg::ST_DATA;
		end else if (dp_cmd.reject) begin
			status_d   = osrb_pkg::ST_REJECT;
		end
	end

	assign dp_status.reject = (in_item.request_count == '0)
	                       || (32'(in_item.request_count) > 32'(MAX_RUN))
	                       || (fill_q == '0)
	                       || (req_ext > fill_q);
	assign dp_status.run_last = (remain_q == osrb_pkg::REQ_W'(1));

	assign pop       = out_valid_q && out_ready;
	assign occupancy = 2'(out_valid_q) + 2'(skid_valid_q) + 2'(valid_s1) - 2'(pop);
	assign dp_status.slot_free = (occupancy < 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q     <= '0;
			wp_q     <= '0;
			fill_q   <= '0;
			cap_q    <= CAP_W'(CAP_RST);
			remain_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (cfg_we) begin
				cap_q  <= cap_wr;
				rp_q   <= '0;
				wp_q   <= '0;
				fill_q <= '0;
			end else if (dp_cmd.clr) begin
				rp_q   <= '0;
				wp_q   <= '0;
				fill_q <= '0;
			end else if (dp_cmd.enq) begin
				wp_q   <= advance(wp_q, cap_q);
				fill_q <= fill_after;
				if (full) begin
					rp_q <= advance(rp_q, cap_q);
				end
			end else if (dp_cmd.step) begin
				rp_q     <= advance(rp_q, cap_q);
				fill_q   <= fill_after;
				remain_q <= remain_q - osrb_pkg::REQ_W'(1);
			end
			if (dp_cmd.load) begin
				remain_q <= in_item.request_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			status_s1  <= status_d;
			fill_s1    <= fill_after;
			last_s1    <= dp_cmd.step ? dp_status.run_last : 1'b1;
			is_data_s1 <= dp_cmd.step;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.enq) begin
			mem[wp_q] <= in_item.sample;
		end
		if (dp_cmd.step) begin
			rd_s1 <= mem[rp_q];
		end
	end

	always_comb begin
		push_item.status     = status_s1;
		push_item.sample_out = is_data_s1 ? rd_s1 : '0;
		push_item.fill_level = fill_s1;
		push_item.last       = last_s1;
	end

	// two-entry output queue: out_q is the head, skid_q catches the one behind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && !pop) begin
			if (valid_s1) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= valid_s1;
		end else begin
			out_valid_q  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && !pop) begin
			if (valid_s1) begin
				skid_q <= push_item;
			end
		end else if (skid_valid_q) begin
			out_q  <= skid_q;
			skid_q <= push_item;
		end else begin
			out_q  <= push_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// File: sv/osrb_checker.sv
// ----------------------------------------------------------------------------
// osrb_checker
// Port-level checks on the result channel of the ring buffer.
// ----------------------------------------------------------------------------
module osrb_checker #(
	parameter int DEPTH = osrb_pkg::DEPTH_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input osrb_pkg::out_item_t out_item
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// non-sample results end their request and carry no sample
	a_ctrl_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != osrb_pkg::ST_DATA
		|-> out_item.last && out_item.sample_out == '0)
		else $error("status result not last or with sample");

	// a dequeued sample leaves at least one slot free
	a_data_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == osrb_pkg::ST_DATA
		|-> 32'(out_item.fill_level) < DEPTH)
		else $error("fill level after dequeue out of range");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind overwriting_sample_ring_buffer osrb_checker #(.DEPTH(DEPTH)) u_osrb_checker (.*);
